// ----- rtl/ifmc_pkg.sv -----
// Shared types and constants for the IR frame message collector.
// No dependencies; imported by ifmc_ctrl, ifmc_dp and the top level.
package ifmc_pkg;

    // payload widths
    localparam int SAMPLE_W   = 10;
    localparam int SENDER_W   = 3;
    localparam int LEN_W      = 4;
    localparam int TEXT_W     = 64;
    localparam int CHAR_W     = 8;
    localparam int S_TDATA_W  = 16;   // sample, padded to bytes
    localparam int M_TDATA_W  = 72;   // length + text, padded to bytes

    // parameter defaults
    localparam int DEF_FRAME_BITS  = 12;
    localparam int DEF_NUM_SENDERS = 8;
    localparam int DEF_MAX_CHARS   = 8;

    localparam logic [SAMPLE_W-1:0] THRESH_RESET = 10'd600;
    localparam logic [CHAR_W-1:0]   EOT_CHAR     = 8'd4;

    // controller -> datapath
    typedef struct packed {
        logic frame_clr;  // restart frame: clear bit count and shift reg
        logic shift;      // shift in the sliced bit of an accepted sample
        logic store;      // append decoded character to its sender row
        logic dump_init;  // point row index at sender 0
        logic dump_rd;    // read row at row index into output regs
        logic dump_next;  // advance row index
        logic dump_end;   // clear all row lengths
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bit_one;    // current sample above threshold
        logic last_bit;   // next shifted bit completes the frame
        logic is_eot;     // decoded character is end of transmission
        logic dump_last;  // row index is the final sender
    } t_dp_status;

endpackage

// ----- rtl/ifmc_dp.sv -----
// Datapath: threshold slicer, frame shifter, row lengths and character memory.
// Depends on ifmc_pkg; driven by ifmc_ctrl commands.
module ifmc_dp #(
    parameter int FRAME_BITS  = ifmc_pkg::DEF_FRAME_BITS,
    parameter int NUM_SENDERS = ifmc_pkg::DEF_NUM_SENDERS,
    parameter int MAX_CHARS   = ifmc_pkg::DEF_MAX_CHARS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ifmc_pkg::SAMPLE_W-1:0]   i_cfg_wr_data,
    input  logic [ifmc_pkg::SAMPLE_W-1:0]   i_sample,
    input  ifmc_pkg::t_dp_cmd               i_cmd,
    output ifmc_pkg::t_dp_status            o_status,
    output logic [ifmc_pkg::SENDER_W-1:0]   o_sender,
    output logic [ifmc_pkg::LEN_W-1:0]      o_length,
    output logic [ifmc_pkg::TEXT_W-1:0]     o_text
);
    import ifmc_pkg::*;

    localparam int CW    = $clog2(FRAME_BITS);
    localparam int SW    = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
    localparam int PW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int ROW_W = MAX_CHARS * CHAR_W;

    logic [SAMPLE_W-1:0]   r_thresh;
    logic [CW-1:0]         r_count;
    logic [FRAME_BITS-1:0] r_shift;
    logic [LEN_W-1:0]      r_len [NUM_SENDERS];
    logic [ROW_W-1:0]      mem [NUM_SENDERS];
    logic [ROW_W-1:0]      r_rd_row;
    logic [LEN_W-1:0]      r_rd_len;
    logic [SW-1:0]         r_idx;

    logic                  bit_one;
    logic [CHAR_W-1:0]     ch;
    logic [SENDER_W-1:0]   snd;
    logic                  snd_ok;
    logic [SW-1:0]         snd_i;
    logic [SW-1:0]         rd_addr;
    logic [LEN_W-1:0]      len_rd;
    logic [PW-1:0]         pos_i;
    logic                  store_we;
    logic [ROW_W-1:0]      masked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    assign bit_one = (i_sample > r_thresh);

    // bit 0 of the frame ends up highest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_shift <= '0;
        end else if (i_cmd.frame_clr) begin
            r_count <= '0;
            r_shift <= '0;
        end else if (i_cmd.shift) begin
            r_count <= r_count + 1'b1;
            r_shift <= {r_shift[FRAME_BITS-2:0], bit_one};
        end
    end

    assign ch     = r_shift[FRAME_BITS-2 -: CHAR_W];
    assign snd    = r_shift[FRAME_BITS-2-CHAR_W -: SENDER_W];
    assign snd_ok = ({1'b0, snd} < (SENDER_W+1)'(NUM_SENDERS));
    assign snd_i  = snd[SW-1:0];

    // one read port on the length file, shared by store and dump
    assign rd_addr  = i_cmd.dump_rd ? r_idx : snd_i;
    assign len_rd   = r_len[rd_addr];
    assign pos_i    = len_rd[PW-1:0];
    assign store_we = i_cmd.store && snd_ok && (len_rd < LEN_W'(MAX_CHARS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SENDERS; s++) begin
                r_len[s] <= '0;
            end
        end else if (i_cmd.dump_end) begin
            for (int s = 0; s < NUM_SENDERS; s++) begin
                r_len[s] <= '0;
            end
        end else if (store_we) begin
            r_len[snd_i] <= len_rd + 1'b1;
        end
    end

    // character memory, byte write, registered row read; not cleared,
    // bytes past the row length are masked on the way out
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            for (int b = 0; b < MAX_CHARS; b++) begin
                if (pos_i == PW'(b)) begin
                    mem[snd_i][b*CHAR_W +: CHAR_W] <= ch;
                end
            end
        end
        if (i_cmd.dump_rd) begin
            r_rd_row <= mem[r_idx];
            r_rd_len <= len_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.dump_init) begin
            r_idx <= '0;
        end else if (i_cmd.dump_next) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        for (int b = 0; b < MAX_CHARS; b++) begin
            masked[b*CHAR_W +: CHAR_W] = (LEN_W'(b) < r_rd_len) ?
                r_rd_row[b*CHAR_W +: CHAR_W] : '0;
        end
    end

    assign o_text   = TEXT_W'(masked);
    assign o_length = r_rd_len;
    assign o_sender = SENDER_W'(r_idx);

    assign o_status.bit_one   = bit_one;
    assign o_status.last_bit  = (r_count == CW'(FRAME_BITS - 1));
    assign o_status.is_eot    = (ch == EOT_CHAR);
    assign o_status.dump_last = (r_idx == SW'(NUM_SENDERS - 1));

endmodule

// ----- rtl/ifmc_ctrl.sv -----
// Controller FSM: sample intake, frame decode and row dump sequencing.
// Depends on ifmc_pkg; commands ifmc_dp.
module ifmc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_m_ready,
    input  ifmc_pkg::t_dp_status  i_status,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    output ifmc_pkg::t_dp_cmd     o_cmd
);
    import ifmc_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_REC      = 3'd1;
    localparam logic [2:0] S_DECODE   = 3'd2;
    localparam logic [2:0] S_DUMP_RD  = 3'd3;
    localparam logic [2:0] S_DUMP_OUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_s_ready = (r_state == S_IDLE) || (r_state == S_REC);
    assign o_m_valid = (r_state == S_DUMP_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid && i_status.bit_one) begin
                    o_cmd.frame_clr = 1'b1;
                    n_state         = S_REC;
                end
            end
            S_REC: begin
                if (i_s_valid) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.last_bit) begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                o_cmd.frame_clr = 1'b1;
                if (i_status.is_eot) begin
                    o_cmd.dump_init = 1'b1;
                    n_state         = S_DUMP_RD;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = S_REC;
                end
            end
            S_DUMP_RD: begin
                o_cmd.dump_rd = 1'b1;
                n_state       = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_m_ready) begin
                    if (i_status.dump_last) begin
                        o_cmd.dump_end = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.dump_next = 1'b1;
                        n_state         = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_valid |-> !o_s_ready)
        else $error("input ready while a row is offered");

    a_decode_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECODE) |=> (r_state == S_REC || r_state == S_DUMP_RD))
        else $error("decode did not resolve in one cycle");

    a_dump_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && i_m_ready && i_status.dump_last) |=> (r_state == S_IDLE))
        else $error("dump did not return to idle");

endmodule

// ----- rtl/ir_frame_message_collector.sv -----
// IR frame message collector: a data frame takes FRAME_BITS accepted samples, then a
// decode state with the input stalled. An end-of-transmission frame goes from decode to a
// row dump that handles each sender row in turn (row read, then row offered), paced by the
// single row read port of the character memory.
// Reset (i_rst_n, synchronous, active low) returns to idle, threshold to 600 and all row
// lengths to zero; the character memory is not cleared, row lengths mask stale bytes.
module ir_frame_message_collector #(
    parameter int FRAME_BITS  = ifmc_pkg::DEF_FRAME_BITS,
    parameter int NUM_SENDERS = ifmc_pkg::DEF_NUM_SENDERS,
    parameter int MAX_CHARS   = ifmc_pkg::DEF_MAX_CHARS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // threshold register write
    input  logic                             i_cfg_wr_en,
    input  logic [ifmc_pkg::SAMPLE_W-1:0]    i_cfg_wr_data,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ifmc_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [9:0] sample, [15:10] zero
    // sender row stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ifmc_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [3:0] length, [67:4] text,
                                                             // [71:68] zero
    output logic [ifmc_pkg::SENDER_W-1:0]    m_axis_tuser,   // [2:0] sender
    output logic                             m_axis_tlast
);
    import ifmc_pkg::*;

    t_dp_cmd             cmd;
    t_dp_status          status;
    logic [SENDER_W-1:0] sender;
    logic [LEN_W-1:0]    length;
    logic [TEXT_W-1:0]   text;

    // FSM: idle hunting for a start level, recording, decode, row dump
    ifmc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (status),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    // slicer, frame shifter, per-sender lengths and character rows
    ifmc_dp #(
        .FRAME_BITS  (FRAME_BITS),
        .NUM_SENDERS (NUM_SENDERS),
        .MAX_CHARS   (MAX_CHARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (s_axis_tdata[SAMPLE_W-1:0]),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_sender      (sender),
        .o_length      (length),
        .o_text        (text)
    );

    // result request: held stable by the datapath regs until taken
    assign m_axis_tdata = M_TDATA_W'({text, length});
    assign m_axis_tuser = sender;
    assign m_axis_tlast = status.dump_last;

endmodule
